// ===== rtl/msl_pkg.sv =====
// Package for the magnitude subtract lower bound block.
// Holds field widths, kind codes and the payload structs. No dependencies.
package msl_pkg;

  localparam int unsigned MantBits = 30;
  localparam int unsigned ExpoBits = 32;
  localparam int unsigned WideBits = 2 * MantBits;
  localparam int unsigned LenBits  = 7;

  typedef enum logic [1:0] {
    KIND_FIN  = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_INF  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]                 x_kind;
    logic [MantBits-1:0]        x_mant;
    logic signed [ExpoBits-1:0] x_expo;
    logic [1:0]                 y_kind;
    logic [MantBits-1:0]        y_mant;
    logic signed [ExpoBits-1:0] y_expo;
  } in_t;

  typedef struct packed {
    logic [1:0]                 z_kind;
    logic [MantBits-1:0]        z_mant;
    logic signed [ExpoBits-1:0] z_expo;
    logic                       expo_underflow;
  } out_t;

  // Decode a two-bit class code; code three counts as infinite.
  function automatic kind_e decode_kind(logic [1:0] k);
    kind_e r;
    if (k[1]) r = KIND_INF;
    else if (k[0]) r = KIND_ZERO;
    else r = KIND_FIN;
    return r;
  endfunction

  // Bit length of a wide value (0 for zero).
  function automatic logic [LenBits-1:0] bit_len(logic [WideBits-1:0] v);
    logic [LenBits-1:0] n;
    n = '0;
    for (int i = 0; i < WideBits; i++) begin
      if (v[i]) n = LenBits'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/msl_if.sv =====
// Valid/ready channel interface carrying one payload struct.
// The payload type is a parameter; no package dependency.
interface msl_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/magnitude_sub_lower_bound.sv =====
// Magnitude subtraction with downward rounding, one transaction per cycle
// unless the receiver stalls. Pipeline: input register, then result
// register. Throughput: one item per cycle unless the receiver stalls, set
// by the single pass of subtract, leading-one count and shift logic.
// Reset: rst_ni clears both valid flags; payload registers are not reset.
// Depends on msl_pkg and msl_if.
module magnitude_sub_lower_bound import msl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  msl_if.sink      in_i,
  msl_if.source    out_o
);

  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q, res_d;
  logic adv;

  // The input stage moves when the result register is free or being drained.
  assign adv       = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
    if (adv && in_vld_q) out_q <= res_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Result computation.
  kind_e                  xk, yk;
  logic signed [ExpoBits:0] xe, ye, sh, base, ez;
  logic [MantBits-1:0]    xm, ym, c, fm;
  logic [MantBits:0]      t;
  logic [WideBits-1:0]    wide, wx, v;
  logic [LenBits-1:0]     len;
  logic                   zero_r, exact, neg;

  always_comb begin
    xk = decode_kind(in_q.x_kind);
    yk = decode_kind(in_q.y_kind);
    xm = in_q.x_mant;
    ym = in_q.y_mant;
    xe = {in_q.x_expo[ExpoBits-1], in_q.x_expo};
    ye = {in_q.y_expo[ExpoBits-1], in_q.y_expo};
    sh = xe - ye;
    t  = {1'b0, ym >> sh[5:0]} + 1'b1;
    c  = xm - t[MantBits-1:0];
    exact = ({1'b0, xm} < t) || (c < MantBits'(1 << (MantBits - 4)));
    wx = WideBits'(xm) << sh[5:0];
    neg = 1'b0;
    zero_r = 1'b0;
    wide = '0;
    v = '0;
    base = xe;
    // Choose the value to normalize and its base exponent.
    if (sh == 0) begin
      v = WideBits'(xm - ym);
      zero_r = ym >= xm;
    end else if (sh <= MantBits) begin
      if (exact) begin
        neg = wx <= WideBits'(ym);
        wide = wx - WideBits'(ym);
        v = wide;
        base = ye;
        zero_r = neg;
      end else begin
        v = WideBits'(c);
      end
    end else begin
      v = WideBits'(xm - 1'b1);
      zero_r = xm == '0;
    end
    len = bit_len(v);
    // Normalize: left-justify so the top of v lands at bit MantBits-1.
    if (len <= MantBits) fm = MantBits'(v << (LenBits'(MantBits) - len));
    else fm = MantBits'(v >> (len - LenBits'(MantBits)));
    ez = base + $signed({{(ExpoBits-LenBits+1){1'b0}}, len}) - $signed((ExpoBits+1)'(MantBits));

    res_d = '0;
    if (yk == KIND_ZERO) begin
      res_d.z_kind = xk;
      if (xk == KIND_FIN) begin
        res_d.z_mant = xm;
        res_d.z_expo = in_q.x_expo;
      end
    end else if (xk == KIND_ZERO || yk == KIND_INF) begin
      res_d.z_kind = KIND_ZERO;
    end else if (xk == KIND_INF) begin
      res_d.z_kind = KIND_INF;
    end else if (sh[ExpoBits] || zero_r || v == '0) begin
      res_d.z_kind = KIND_ZERO;
    end else if (ez < ($signed({1'b1, {(ExpoBits){1'b0}}}) >>> 1)) begin
      res_d.z_kind = KIND_ZERO;
      res_d.expo_underflow = 1'b1;
    end else begin
      res_d.z_kind = KIND_FIN;
      res_d.z_mant = fm;
      res_d.z_expo = ez[ExpoBits-1:0];
    end
  end

endmodule

// ===== rtl/msl_checker.sv =====
// Port-level checker for magnitude_sub_lower_bound, with its bind.
// Depends on msl_pkg.
module msl_checker import msl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.z_kind != KIND_FIN |-> out_data.z_expo == '0) else $error("expo");
  a_uf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.expo_underflow |-> out_data.z_kind == KIND_ZERO) else $error("uf");
endmodule

bind magnitude_sub_lower_bound msl_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_o.valid),
  .out_ready(out_o.ready), .out_data(out_o.data)
);

// ===== tb/tb_top.sv =====
// Testbench for magnitude_sub_lower_bound: directed and random operands,
// a predictor of the rounded-down difference, and a scoreboard of results.
// Depends on msl_pkg, msl_if and the block itself.
module tb_top;
  import msl_pkg::*;

  logic clk_i;
  logic rst_ni;

  msl_if #(.T(in_t))  in_ch ();
  msl_if #(.T(out_t)) out_ch ();

  magnitude_sub_lower_bound dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  localparam int WatchLimit = 20000;

  // Idling phases: none, sender idle, receiver stall, both.
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} phase_e;

  in_t    pending_ops[$];
  out_t   expected_diffs[$];
  phase_e phase;
  bit     hold_sender;
  bit     stim_done;
  int     fail_count;
  int     idle_cycles;

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic out_t place_finite(logic [63:0] m, longint e, longint delta);
    out_t   r;
    longint lowest;
    r = '0;
    r.z_kind = KIND_ZERO;
    lowest = -(longint'(1) <<< (ExpoBits - 1));
    if (m == 0) return r;
    if (e + delta < lowest) begin
      r.expo_underflow = 1'b1;
      return r;
    end
    r.z_kind = KIND_FIN;
    r.z_mant = m[MantBits-1:0];
    r.z_expo = ExpoBits'(e + delta);
    return r;
  endfunction

  // Normalize a mantissa and apply the exponent offset, flagging underflow.
  function automatic out_t norm_result(logic [63:0] m, longint e);
    out_t r;
    int   fix;
    r = '0;
    r.z_kind = KIND_ZERO;
    if (m == 0) return r;
    fix = 0;
    while (m[MantBits-1] == 1'b0) begin
      m = m << 1;
      fix++;
    end
    return place_finite(m, e, -fix);
  endfunction

  // Predict the lower bound of max(x - y, 0).
  function automatic out_t predict_diff(in_t op);
    out_t         r;
    kind_e        xk, yk;
    longint       xe, ye, s;
    logic [127:0] wide;
    logic [63:0]  t, m;
    int           len;
    r = '0;
    r.z_kind = KIND_ZERO;
    xk = op.x_kind[1] ? KIND_INF : (op.x_kind[0] ? KIND_ZERO : KIND_FIN);
    yk = op.y_kind[1] ? KIND_INF : (op.y_kind[0] ? KIND_ZERO : KIND_FIN);
    xe = longint'(op.x_expo);
    ye = longint'(op.y_expo);
    if (yk == KIND_ZERO) begin
      r.z_kind = xk;
      if (xk == KIND_FIN) begin
        r.z_mant = op.x_mant;
        r.z_expo = op.x_expo;
      end
      return r;
    end
    if (xk == KIND_ZERO || yk == KIND_INF) return r;
    if (xk == KIND_INF) begin
      r.z_kind = KIND_INF;
      return r;
    end
    if (xe < ye) return r;
    if (xe == ye) begin
      if (op.y_mant >= op.x_mant) return r;
      return norm_result(64'(op.x_mant - op.y_mant), xe);
    end
    s = xe - ye;
    if (s <= MantBits) begin
      t = (64'(op.y_mant) >> s) + 64'd1;
      if (64'(op.x_mant) < t || 64'(op.x_mant) - t < (64'd1 << (MantBits - 4))) begin
        // Heavy cancellation: exact difference truncated to the mantissa width.
        wide = (128'(op.x_mant) << s);
        if (wide <= 128'(op.y_mant)) return r;
        wide = wide - 128'(op.y_mant);
        len = 0;
        for (int i = 0; i < 128; i++) if (wide[i]) len = i + 1;
        if (len <= MantBits) m = 64'(wide << (MantBits - len));
        else m = 64'(wide >> (len - MantBits));
        return place_finite(m & ((64'd1 << MantBits) - 1), ye,
                            longint'(len) - longint'(MantBits));
      end
      return norm_result(64'(op.x_mant) - t, xe);
    end
    if (op.x_mant == 0) return r;
    return norm_result(64'(op.x_mant) - 64'd1, xe);
  endfunction

  function automatic logic [MantBits-1:0] rand_mant(bit normal);
    logic [MantBits-1:0] m;
    m = MantBits'($urandom);
    if (normal) m[MantBits-1] = 1'b1;
    return m;
  endfunction

  // Build one random operand pair; mostly finite, normalized and close exponents.
  function automatic in_t rand_op();
    in_t op;
    int  sel;
    op.x_kind = ($urandom_range(0, 9) == 0) ? 2'($urandom) : KIND_FIN;
    op.y_kind = ($urandom_range(0, 9) == 0) ? 2'($urandom) : KIND_FIN;
    op.x_mant = rand_mant($urandom_range(0, 19) != 0);
    op.y_mant = rand_mant($urandom_range(0, 19) != 0);
    op.x_expo = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 3) op.y_expo = op.x_expo;
    else if (sel < 8) op.y_expo = op.x_expo - $urandom_range(0, 34);
    else op.y_expo = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      // Close mantissas for cancellation, sometimes near the exponent floor.
      op.y_mant = op.x_mant ^ MantBits'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) op.x_expo = 32'h8000_0000 + $urandom_range(0, 40);
      op.y_expo = op.x_expo - $urandom_range(0, 2);
    end
    return op;
  endfunction

  // Stimulus: directed cases, then random items over four idling phases.
  initial begin
    in_t op;
    in_t base;
    stim_done   = 1'b0;
    hold_sender = 1'b0;
    phase       = PH_NONE;
    base.x_kind = KIND_FIN;
    base.x_mant = 30'h2000_0000;
    base.x_expo = 10;
    base.y_kind = KIND_FIN;
    base.y_mant = 30'h2000_0000;
    base.y_expo = 5;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        op = base;
        op.x_kind = 2'(k);
        op.y_kind = 2'(j);
        pending_ops.push_back(op);
      end
    end
    // Zero y with a non-normalized x, equal operands, shift past width, floor cases.
    op = base; op.y_kind = KIND_ZERO; op.x_mant = 30'h5; pending_ops.push_back(op);
    op = base; op.y_expo = 10; pending_ops.push_back(op);
    op = base; op.x_mant = '1; op.y_expo = 10; pending_ops.push_back(op);
    op = base; op.y_expo = 32'h8000_0000; op.x_expo = 32'h7FFF_FFFF; pending_ops.push_back(op);
    op = base; op.x_mant = 30'h3FFF_FFFF; op.y_mant = 30'h3FFF_FFFF; op.y_expo = 9;
    pending_ops.push_back(op);
    op = base; op.x_expo = 32'h8000_0000; op.y_expo = 32'h8000_0001; pending_ops.push_back(op);
    op = base; op.x_expo = 32'h8000_0001; op.y_expo = 32'h8000_0000;
    op.y_mant = 30'h3FFF_FFFF; pending_ops.push_back(op);
    op = base; op.x_mant = 0; op.y_expo = -100; pending_ops.push_back(op);
    op = base; op.x_mant = 30'h2000_0001; op.y_mant = 30'h3FFF_FFFF; op.y_expo = 9;
    pending_ops.push_back(op);

    wait (rst_ni);
    for (int p = 0; p < 4; p++) begin
      phase = phase_e'(p);
      for (int i = 0; i < 490; i++) pending_ops.push_back(rand_op());
      wait (pending_ops.size() == 0);
      if (p == 1) begin
        // Let the pipeline drain completely before going on.
        hold_sender = 1'b1;
        wait (expected_diffs.size() == 0);
        hold_sender = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // Driver: presents queued operands, idling at random in the sender phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) void'(pending_ops.pop_front());
      if (in_ch.valid && pending_ops.size() > 0 && !hold_sender)
        expected_diffs.push_back(predict_diff(in_ch.data));
      else if (in_ch.valid)
        expected_diffs.push_back(predict_diff(in_ch.data));
      if (pending_ops.size() > 0 && !hold_sender &&
          !((phase == PH_SEND && $urandom_range(0, 99) < 46) ||
            (phase == PH_BOTH && $urandom_range(0, 99) < 6))) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_ops[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random in the receiver phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !((phase == PH_RECV && $urandom_range(0, 99) < 46) ||
                           (phase == PH_BOTH && $urandom_range(0, 99) < 6));
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_diffs.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_diffs.pop_front();
        if (out_ch.data.z_kind !== want.z_kind) begin
          $error("z_kind: expected %0d, got %0d", want.z_kind, out_ch.data.z_kind);
          fail_count++;
        end
        if (out_ch.data.z_mant !== want.z_mant) begin
          $error("z_mant: expected %h, got %h", want.z_mant, out_ch.data.z_mant);
          fail_count++;
        end
        if (out_ch.data.z_expo !== want.z_expo) begin
          $error("z_expo: expected %0d, got %0d", want.z_expo, out_ch.data.z_expo);
          fail_count++;
        end
        if (out_ch.data.expo_underflow !== want.expo_underflow) begin
          $error("expo_underflow: expected %0d, got %0d", want.expo_underflow,
                 out_ch.data.expo_underflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset and end of run.
  initial begin
    fail_count  = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !in_ch.valid && expected_diffs.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_diffs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== magnitude_sub_lower_bound.f =====
rtl/msl_pkg.sv
rtl/msl_if.sv
rtl/magnitude_sub_lower_bound.sv
rtl/msl_checker.sv
tb/tb_top.sv
